// ----- rtl/imconv_pkg.sv -----
// shared types and constants of the 3x3 image convolution
`timescale 1ns / 1ps

package imconv_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = COEF_W + PIX_W + 1;
    localparam int ROW_SUM_W  = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;
    localparam int CFG_WIDTH_W = 12;
    localparam int HGT_W      = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int KROW_W     = 3 * COEF_W;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int PIX_MAX    = 255;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [KROW_W-1:0] KERNEL_MID_RESET = 48'h0000_1000_0000;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_KERNEL_TOP,
        REG_KERNEL_MID,
        REG_KERNEL_BOTTOM
    } reg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_entry_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
    } tap_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } result_t;

endpackage

// ----- rtl/imconv_if.sv -----
// stream interfaces for pixel beats and result beats
`timescale 1ns / 1ps

interface imconv_pix_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output command, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink (input valid, input command, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

interface imconv_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input frame_last, output ready);
endinterface

// ----- rtl/imconv_line.sv -----
// two-row line memory with read-modify-write and forwarding, yields one column per beat
`timescale 1ns / 1ps

module imconv_line #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  imconv_pkg::pixel_t            bot,
    output logic                          col_valid,
    output imconv_pkg::pixel_t            col_top,
    output imconv_pkg::pixel_t            col_mid,
    output imconv_pkg::pixel_t            col_bot
);

    localparam int CW = $clog2(MAX_WIDTH);

    imconv_pkg::line_entry_t mem [MAX_WIDTH];

    logic                    valid1_reg;
    logic                    fwd_hit_reg;
    logic [CW-1:0]           addr1_reg;
    imconv_pkg::pixel_t      bot1_reg;
    imconv_pkg::line_entry_t rd_reg;
    imconv_pkg::line_entry_t fwd_data_reg;
    imconv_pkg::line_entry_t entry;
    imconv_pkg::line_entry_t wdata;

    always_comb
    begin
        entry       = fwd_hit_reg ? fwd_data_reg : rd_reg;
        wdata.upper = entry.lower;
        wdata.lower = bot1_reg;
    end

    assign col_valid = valid1_reg;
    assign col_top   = entry.upper;
    assign col_mid   = entry.lower;
    assign col_bot   = bot1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            valid1_reg  <= adv;
            fwd_hit_reg <= adv && valid1_reg && (addr1_reg == addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr1_reg <= addr;
            bot1_reg  <= bot;
        end
        fwd_data_reg <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (valid1_reg)
        begin
            mem[addr1_reg] <= wdata;
        end
        if (adv)
        begin
            rd_reg <= mem[addr];
        end
    end

endmodule

// ----- rtl/imconv_filter.sv -----
// 3x3 window, tap products, adder tree, rounding and clamping
`timescale 1ns / 1ps

module imconv_filter #(
    parameter int KERNEL_SIZE    = 3,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 col_valid,
    input  imconv_pkg::pixel_t                   col_top,
    input  imconv_pkg::pixel_t                   col_mid,
    input  imconv_pkg::pixel_t                   col_bot,
    input  imconv_pkg::tap_ctl_t                 tag_in,
    input  logic [imconv_pkg::KROW_W-1:0]        kernel_top,
    input  logic [imconv_pkg::KROW_W-1:0]        kernel_mid,
    input  logic [imconv_pkg::KROW_W-1:0]        kernel_bottom,
    output logic                                 res_valid,
    output imconv_pkg::result_t                  res
);

    localparam int  PW  = imconv_pkg::PROD_W;
    localparam int  RW  = imconv_pkg::ROW_SUM_W;
    localparam int  SW  = imconv_pkg::SUM_W;
    localparam int  CFW = imconv_pkg::COEF_W;
    localparam bit  CENTRE_ONLY = (KERNEL_SIZE < 2);

    imconv_pkg::pixel_t   win_reg [3][3];
    imconv_pkg::tap_ctl_t tag2_reg;
    logic                 v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                 last3_reg, last4_reg, last5_reg;

    logic signed [PW-1:0] prod_next [3][9];
    logic signed [PW-1:0] prod_reg  [3][9];
    logic signed [RW-1:0] rsum_next [3][3];
    logic signed [RW-1:0] rsum_reg  [3][3];
    logic signed [SW-1:0] sum_next  [3];
    logic signed [SW-1:0] sum_reg   [3];
    logic [7:0]           chan_next [3];
    imconv_pkg::result_t  res_reg;

    logic [imconv_pkg::KROW_W-1:0] krow [3];
    logic                          row_ok [3];
    logic                          col_ok [3];

    function automatic logic [7:0] pick(imconv_pkg::pixel_t p, int ch);
        logic [7:0] v;
        case (ch)
            0:       v = p.red;
            1:       v = p.green;
            default: v = p.blue;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] finish(logic signed [SW-1:0] s);
        logic signed [SW:0] biased;
        logic signed [SW:0] shifted;
        logic [7:0]         v;
        biased  = (SW+1)'(s) + (SW+1)'(1 << (COEF_FRAC_BITS - 1));
        shifted = biased >>> COEF_FRAC_BITS;
        if (s <= 0)
            v = 8'd0;
        else if (shifted > imconv_pkg::PIX_MAX)
            v = 8'(imconv_pkg::PIX_MAX);
        else
            v = shifted[7:0];
        return v;
    endfunction

    assign krow[0] = kernel_top;
    assign krow[1] = kernel_mid;
    assign krow[2] = kernel_bottom;

    always_comb
    begin
        row_ok[0] = tag2_reg.up_ok;
        row_ok[1] = 1'b1;
        row_ok[2] = tag2_reg.down_ok;
        col_ok[0] = tag2_reg.left_ok;
        col_ok[1] = 1'b1;
        col_ok[2] = tag2_reg.right_ok;
    end

    // window index is [column][row]
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if ((CENTRE_ONLY && (r != 1 || c != 1)) || !row_ok[r] || !col_ok[c])
                        prod_next[ch][3*r+c] = '0;
                    else
                        prod_next[ch][3*r+c] = $signed(krow[r][CFW*c +: CFW])
                                             * $signed({1'b0, pick(win_reg[c][r], ch)});
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rsum_next[ch][r] = RW'(prod_reg[ch][3*r]) + RW'(prod_reg[ch][3*r+1])
                                 + RW'(prod_reg[ch][3*r+2]);
            end
            sum_next[ch] = SW'(rsum_reg[ch][0]) + SW'(rsum_reg[ch][1])
                         + SW'(rsum_reg[ch][2]);
            chan_next[ch] = finish(sum_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= col_valid && tag_in.emit;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_valid)
        begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= col_top;
            win_reg[2][1] <= col_mid;
            win_reg[2][2] <= col_bot;
            tag2_reg      <= tag_in;
        end
        prod_reg      <= prod_next;
        last3_reg     <= tag2_reg.last;
        rsum_reg      <= rsum_next;
        last4_reg     <= last3_reg;
        sum_reg       <= sum_next;
        last5_reg     <= last4_reg;
        res_reg.red   <= chan_next[0];
        res_reg.green <= chan_next[1];
        res_reg.blue  <= chan_next[2];
        res_reg.last  <= last5_reg;
    end

    assign res_valid = v6_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/image_convolution_3x3.sv -----
// top level of the streaming 3x3 RGB convolution
`timescale 1ns / 1ps

// Takes one pixel beat per clock in raster order while the output queue has
// room and returns one filtered beat per clock once the stream is primed and
// the consumer is ready; a result for pixel (r,c) is released by the beat at
// position r*W+c+W+1, so W+1 drain beats flush a frame, and frame_last marks
// its final result. An accepted beat reaches the output queue through the line
// memory read, the window, product and two adder stages and the rounding stage.
// The line memory is a single-port-read, single-port-write array of MAX_WIDTH
// entries that holds the two previous rows per column, read and written back
// once per beat with forwarding between neighbouring beats. Geometry writes
// restart the frame; kernel writes act at once. Registers sit at byte
// addresses 8*i: width, height, kernel rows top, middle and bottom.

module image_convolution_3x3 #(
    parameter int MAX_WIDTH      = 2048,
    parameter int KERNEL_SIZE    = 3,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    imconv_pix_if.sink                          pix_in,
    imconv_res_if.source                        res_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [imconv_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [imconv_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [imconv_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > imconv_pkg::CFG_WIDTH_W) ? WW : imconv_pkg::CFG_WIDTH_W;
    localparam int HW = imconv_pkg::HGT_W;
    localparam int KW = imconv_pkg::KROW_W;
    localparam int FIFO_DEPTH = 16;
    localparam int FP = $clog2(FIFO_DEPTH);

    // configuration registers
    logic [imconv_pkg::CFG_WIDTH_W-1:0] width_reg;
    logic [HW-1:0]                      height_reg;
    logic [KW-1:0]                      ktop_reg, kmid_reg, kbot_reg;
    logic                               cfg_wr;
    logic                               geo_wr;
    imconv_pkg::reg_index_t             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = imconv_pkg::reg_index_t'(paddr[5:3]);

    always_comb
    begin
        geo_wr = 1'b0;
        prdata = '0;
        unique case (cfg_idx)
            imconv_pkg::REG_IMAGE_WIDTH:
            begin
                geo_wr = cfg_wr;
                prdata = imconv_pkg::APB_DATA_W'(width_reg);
            end
            imconv_pkg::REG_IMAGE_HEIGHT:
            begin
                geo_wr = cfg_wr;
                prdata = imconv_pkg::APB_DATA_W'(height_reg);
            end
            imconv_pkg::REG_KERNEL_TOP:    prdata = imconv_pkg::APB_DATA_W'(ktop_reg);
            imconv_pkg::REG_KERNEL_MID:    prdata = imconv_pkg::APB_DATA_W'(kmid_reg);
            imconv_pkg::REG_KERNEL_BOTTOM: prdata = imconv_pkg::APB_DATA_W'(kbot_reg);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= imconv_pkg::CFG_WIDTH_W'(1);
            height_reg <= HW'(1);
            ktop_reg   <= '0;
            kmid_reg   <= imconv_pkg::KERNEL_MID_RESET;
            kbot_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                imconv_pkg::REG_IMAGE_WIDTH:   width_reg  <= pwdata[imconv_pkg::CFG_WIDTH_W-1:0];
                imconv_pkg::REG_IMAGE_HEIGHT:  height_reg <= pwdata[HW-1:0];
                imconv_pkg::REG_KERNEL_TOP:    ktop_reg   <= pwdata[KW-1:0];
                imconv_pkg::REG_KERNEL_MID:    kmid_reg   <= pwdata[KW-1:0];
                imconv_pkg::REG_KERNEL_BOTTOM: kbot_reg   <= pwdata[KW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective geometry
    logic [EW-1:0] w_ext, w_clamp;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext == '0)
            w_clamp = EW'(1);
        else if (w_ext > EW'(MAX_WIDTH))
            w_clamp = EW'(MAX_WIDTH);
        else
            w_clamp = w_ext;
        w_eff = w_clamp[WW-1:0];
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (height_reg > HW'(imconv_pkg::HEIGHT_LIMIT))
            h_eff = HW'(imconv_pkg::HEIGHT_LIMIT);
        else
            h_eff = height_reg;
    end

    // position counters
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [HW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic          accept, adv, emit, flush, in_wrap, out_wrap, last;
    logic          fifo_push, fifo_pop;
    logic [FP:0]   reserve_reg;
    imconv_pkg::tap_ctl_t tag_next, tag1_reg;
    imconv_pkg::pixel_t   bot_pix;

    assign pix_in.ready = (reserve_reg != (FP+1)'(FIFO_DEPTH));
    assign accept   = pix_in.valid && pix_in.ready;
    assign flush    = (in_row_reg >= h_eff);
    assign adv      = accept && (flush || pix_in.command == imconv_pkg::CMD_PIXEL);
    assign emit     = (in_row_reg > HW'(1)) || (in_row_reg == HW'(1) && in_col_reg != '0);
    assign in_wrap  = (WW'(in_col_reg) + WW'(1)) == w_eff;
    assign out_wrap = (WW'(out_col_reg) + WW'(1)) == w_eff;
    assign last     = (out_row_reg == h_eff - HW'(1)) && out_wrap;

    always_comb
    begin
        tag_next.emit     = emit;
        tag_next.last     = last;
        tag_next.up_ok    = (out_row_reg != '0);
        tag_next.down_ok  = (out_row_reg + HW'(1)) < h_eff;
        tag_next.left_ok  = (out_col_reg != '0);
        tag_next.right_ok = !out_wrap;
        bot_pix.red   = flush ? '0 : pix_in.in_red;
        bot_pix.green = flush ? '0 : pix_in.in_green;
        bot_pix.blue  = flush ? '0 : pix_in.in_blue;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (geo_wr || (adv && emit && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (adv)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit)
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            tag1_reg    <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (adv)
                tag1_reg <= tag_next;
        end
    end

    // line memory and filter datapath
    logic               col_valid;
    imconv_pkg::pixel_t col_top, col_mid, col_bot;
    logic               res_valid;
    imconv_pkg::result_t res;

    imconv_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .addr      (in_col_reg),
        .bot       (bot_pix),
        .col_valid (col_valid),
        .col_top   (col_top),
        .col_mid   (col_mid),
        .col_bot   (col_bot)
    );

    imconv_filter #(
        .KERNEL_SIZE    (KERNEL_SIZE),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_filter (
        .clk           (clk),
        .rst_n         (rst_n),
        .col_valid     (col_valid),
        .col_top       (col_top),
        .col_mid       (col_mid),
        .col_bot       (col_bot),
        .tag_in        (tag1_reg),
        .kernel_top    (ktop_reg),
        .kernel_mid    (kmid_reg),
        .kernel_bottom (kbot_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // output queue, space reserved at accept
    imconv_pkg::result_t fifo_mem [FIFO_DEPTH];
    logic [FP-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [FP:0]         count_reg;

    assign fifo_push = res_valid;
    assign fifo_pop  = res_out.valid && res_out.ready;

    assign res_out.valid      = (count_reg != '0);
    assign res_out.out_red    = fifo_mem[rd_ptr_reg].red;
    assign res_out.out_green  = fifo_mem[rd_ptr_reg].green;
    assign res_out.out_blue   = fifo_mem[rd_ptr_reg].blue;
    assign res_out.frame_last = fifo_mem[rd_ptr_reg].last;

    always_ff @(posedge clk)
    begin
        if (fifo_push)
            fifo_mem[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            reserve_reg <= '0;
        end
        else
        begin
            if (fifo_push)
                wr_ptr_reg <= wr_ptr_reg + FP'(1);
            if (fifo_pop)
                rd_ptr_reg <= rd_ptr_reg + FP'(1);
            count_reg   <= count_reg + (FP+1)'(fifo_push) - (FP+1)'(fifo_pop);
            reserve_reg <= reserve_reg + (FP+1)'(adv && emit) - (FP+1)'(fifo_pop);
        end
    end

endmodule
